### hdl/sobel_edge_magnitude_rgb_assert.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared concurrent check macros for the edge magnitude block.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SOBM_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sobm check failed");
`define SOBM_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobm implication failed");
`else
`define SOBM_CHECK(lbl, expr)
`define SOBM_IMPLY(lbl, ante, cons)
`endif
`endif

### hdl/sobm_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Sizes, register indexes, sequencer codes and lane handshake types.
// ----------------------------------------------------------------------------
package sobm_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 13;
  localparam int PIX_W      = 24;
  localparam int SQRT_STEPS = 11;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_GRAD   = 6'b000100,
    S_WAIT   = 6'b001000,
    S_OUT    = 6'b010000,
    S_UPDATE = 6'b100000
  } seq_state_t;

  typedef struct packed {
    logic start;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;
endpackage

### hdl/sobm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sobm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/sobm_lane.sv
// ----------------------------------------------------------------------------
// Sobel channel lane
// Gradients of one color channel, squared sum, bit-pair square root, rounding.
// ----------------------------------------------------------------------------
module sobm_lane
  import sobm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lane_ctrl_t       ctrl,
  input  logic [2:0][7:0]  left,
  input  logic [2:0][7:0]  mid,
  input  logic [2:0][7:0]  right,
  output lane_stat_t       stat,
  output logic [7:0]       mag
);
  logic [9:0]  sum_l, sum_r, sum_t, sum_b;
  logic [9:0]  ax, ay;
  logic [19:0] sqx, sqy;
  logic [20:0] rem;
  logic [21:0] res, bitv, trial;
  logic [3:0]  step;
  logic        sq_pend, run, done;
  logic [11:0] rnd;

  assign sum_l = {2'b00, left[0]} + {1'b0, left[1], 1'b0} + {2'b00, left[2]};
  assign sum_r = {2'b00, right[0]} + {1'b0, right[1], 1'b0} + {2'b00, right[2]};
  assign sum_t = {2'b00, left[0]} + {1'b0, mid[0], 1'b0} + {2'b00, right[0]};
  assign sum_b = {2'b00, left[2]} + {1'b0, mid[2], 1'b0} + {2'b00, right[2]};
  assign sqx   = ax * ax;
  assign sqy   = ay * ay;
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      ax <= (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
      ay <= (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
    end
    if (sq_pend) begin
      rem  <= {1'b0, sqx} + {1'b0, sqy};
      res  <= '0;
      bitv <= 22'h100000;
    end else if (run) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[20:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pend <= 1'b0;
      run     <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        sq_pend <= 1'b1;
      end else if (sq_pend) begin
        sq_pend <= 1'b0;
        run     <= 1'b1;
        step    <= '0;
      end else if (run) begin
        step <= step + 4'd1;
        if (step == 4'(SQRT_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rnd       = ({1'b0, rem} > res) ? {1'b0, res[10:0]} + 12'd1 : {1'b0, res[10:0]};
  assign mag       = (rnd > 12'd255) ? 8'd255 : rnd[7:0];
  assign stat.busy = sq_pend | run;
  assign stat.done = done;
endmodule

### hdl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Line stores, 3x3 window, three channel lanes and the result merge stage.
// ----------------------------------------------------------------------------
// Flow: an accepted pixel passes S_READ, then S_GRAD, S_WAIT and S_OUT for
//   each of its results (none in the first row, up to two at a row end), then
//   S_UPDATE; s_tready is high only in S_IDLE, so no new pixel is taken until
//   the last one is done. The 11-step square root in each lane and any hold-off
//   by the receiver lengthen the time per pixel.
// Reset: synchronous; clears counters, window and sequencer, sets width 640
//   and height 480. Line stores need no clearing.
module sobel_edge_magnitude_rgb
  import sobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red_edge, green_edge, blue_edge, out_row, out_column
  output logic        m_tlast,
  output logic        m_tuser,   // frame_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  seq_state_t state;
  logic [10:0] width_r, w_eff;
  logic [12:0] height_r, h_eff;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row, row_m1;
  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] px_q, cur0, cur1, cur2, up_rd, mid_rd;
  logic row_end_q, emit1_q, emit2_q, sel;
  logic accept, out_load;
  logic [2:0][PIX_W-1:0] col_l, col_m, col_r;
  lane_ctrl_t lane_ctrl;
  lane_stat_t lane_stat [3];
  logic [7:0] lane_mag [3];
  logic [7:0] red_edge, green_edge, blue_edge;
  logic [11:0] out_row;
  logic [COL_W-1:0] out_column;

  assign w_eff = (width_r == 11'd0) ? 11'd1 :
                 (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == 13'd0) ? 13'd1 :
                 (height_r > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_r;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign row_m1   = row - 13'd1;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);
  assign lane_ctrl.start = (state == S_GRAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(state == S_READ), .waddr(col), .wdata(mid_rd),
    .raddr(col), .rdata(up_rd)
  );
  sobm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(state == S_READ), .waddr(col), .wdata(px_q),
    .raddr(col), .rdata(mid_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      px_q      <= (!s_tuser && row < h_eff) ?
                   {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]} : '0;
      row_end_q <= ({1'b0, col} >= w_eff - 11'd1);
      emit1_q   <= (row != '0) && (col != '0);
      emit2_q   <= (row != '0) && ({1'b0, col} >= w_eff - 11'd1);
    end
    if (state == S_READ) begin
      cur0 <= (row >= 13'd2) ? up_rd : '0;
      cur1 <= (row != '0) ? mid_rd : '0;
      cur2 <= px_q;
    end
  end

  always_comb begin
    if (sel) begin
      col_l = (col != '0) ? {win[5], win[4], win[3]} : '0;
      col_m = {cur2, cur1, cur0};
      col_r = '0;
    end else begin
      col_l = {win[2], win[1], win[0]};
      col_m = {win[5], win[4], win[3]};
      col_r = {cur2, cur1, cur0};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [2:0][7:0] ll, lm, lr;
    for (genvar j = 0; j < 3; j++) begin : g_tap
      assign ll[j] = col_l[j][8*(2-k) +: 8];
      assign lm[j] = col_m[j][8*(2-k) +: 8];
      assign lr[j] = col_r[j][8*(2-k) +: 8];
    end
    sobm_lane u_lane (
      .clk(clk), .rst(rst), .ctrl(lane_ctrl), .left(ll), .mid(lm), .right(lr),
      .stat(lane_stat[k]), .mag(lane_mag[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      col   <= '0;
      row   <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_READ;
        end
        S_READ: begin
          if (emit1_q) begin
            sel   <= 1'b0;
            state <= S_GRAD;
          end else if (emit2_q) begin
            sel   <= 1'b1;
            state <= S_GRAD;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_GRAD: state <= S_WAIT;
        S_WAIT: begin
          if (lane_stat[0].done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (!sel && emit2_q) begin
              sel   <= 1'b1;
              state <= S_GRAD;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (row_end_q) begin
            for (int i = 0; i < 6; i++) win[i] <= '0;
            col <= '0;
            row <= (row >= h_eff) ? '0 : row + 13'd1;
          end else begin
            win[0] <= win[3];
            win[1] <= win[4];
            win[2] <= win[5];
            win[3] <= cur0;
            win[4] <= cur1;
            win[5] <= cur2;
            col    <= col + 10'd1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_edge   <= lane_mag[0];
      green_edge <= lane_mag[1];
      blue_edge  <= lane_mag[2];
      out_row    <= row_m1[11:0];
      out_column <= sel ? col : col - 10'd1;
      m_tlast    <= sel ? 1'b1 : !row_end_q;
      m_tuser    <= sel && (row_m1 == h_eff - 13'd1) && ({1'b0, col} == w_eff - 11'd1);
    end
  end

  assign m_tdata = {2'b00, out_column, out_row, blue_edge, green_edge, red_edge};

`include "sobel_edge_magnitude_rgb_assert.svh"
  `SOBM_IMPLY(a_accept_reads, accept, state == S_READ)
  `SOBM_CHECK(a_lanes_agree, lane_stat[0].done == lane_stat[1].done &&
                             lane_stat[1].done == lane_stat[2].done)
  `SOBM_IMPLY(a_out_loads, out_load, m_tvalid)
  `SOBM_CHECK(a_done_in_wait, !lane_stat[0].done || state == S_WAIT)
endmodule
